@@ sv/bizm_pkg.sv @@
// Shared constants, types and code names for the binary image zone majority block.
package bizm_pkg;

    // Frame limits and grid shape.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int GRID_COLS  = 3;
    localparam int GRID_ROWS  = 4;
    localparam int NUM_CELLS  = GRID_COLS * GRID_ROWS;

    // Configuration register widths, indexes and reset values.
    localparam int CFG_W            = 11;
    localparam int CFG_IDX_W        = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_WIDTH_RST  = 11'd32;
    localparam logic [CFG_W-1:0]     CFG_HEIGHT_RST = 11'd32;

    // Derived widths.
    localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int POS_W    = $clog2(MAX_DIM);
    localparam int CMP_W    = (CFG_W > DIM_W) ? CFG_W : DIM_W;
    localparam int COUNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int CELL_W   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int GX_W     = $clog2(GRID_COLS + 1);
    localparam int GY_W     = $clog2(GRID_ROWS + 1);
    localparam int STEP_W   = $clog2(COUNT_W + 1);

    // Reciprocals for the cell size: q = (d * RECIP) >> DIM_W is at most one low.
    localparam int RECIP_W  = DIM_W + 1;
    localparam int PROD_W   = DIM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_X = RECIP_W'((1 << DIM_W) / GRID_COLS);
    localparam logic [RECIP_W-1:0] RECIP_Y = RECIP_W'((1 << DIM_W) / GRID_ROWS);

    // Cycles the cell sizes need after a reset or a register write.
    localparam int SETTLE_W = 2;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

    // Pixel and result encodings.
    localparam logic [7:0] WHITE_LEVEL = 8'hFF;
    localparam int IDX_W  = 4;
    localparam int VOTE_W = 2;
    localparam logic signed [VOTE_W-1:0] VOTE_UP   = 2'sb01;
    localparam logic signed [VOTE_W-1:0] VOTE_DOWN = 2'sb11;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_START,
        ST_DIV,
        ST_RD,
        ST_MUL,
        ST_CMP,
        ST_HOLD
    } t_state;

endpackage

@@ sv/binary_image_zone_majority_core.sv @@
// Top level of the binary image zone majority block: pixel counting, cell memory and voting.
// Results: a pixel that does not close a frame gives no result; the frame's last pixel starts
//   one result per cell, each held until it is taken.
// Throughput: one pixel per cycle inside a frame; each frame end holds the input off until
//   every cell result is taken (serial divider unless the frame had no dark pixel, then one memory read per cell).
// Reset is synchronous and active low; it and every register write hold the input off
//   while the cell sizes are recomputed, and mark all cell entries empty.
module binary_image_zone_majority_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [bizm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bizm_pkg::CFG_W-1:0]         i_cfg_data,
    // Pixel channel.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_red,
    input  logic [7:0]                         i_green,
    input  logic [7:0]                         i_blue,
    // Cell result channel.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [bizm_pkg::IDX_W-1:0]         o_cell_index,
    output logic signed [bizm_pkg::VOTE_W-1:0] o_cell_vote,
    output logic                               o_no_dark_flag,
    output logic                               o_last_cell
);

    localparam int CW = bizm_pkg::COUNT_W;
    localparam int MW = 2 * bizm_pkg::COUNT_W;

    // ------------------------------------------------------------------
    // Configuration registers and the derived frame and cell sizes.
    // ------------------------------------------------------------------
    logic [bizm_pkg::CFG_W-1:0]    r_cfg_width;
    logic [bizm_pkg::CFG_W-1:0]    r_cfg_height;
    logic [bizm_pkg::SETTLE_W-1:0] r_settle;

    logic [bizm_pkg::DIM_W-1:0]  w_clamp, h_clamp;
    logic [bizm_pkg::PROD_W-1:0] w_prod, h_prod;
    logic [bizm_pkg::DIM_W-1:0]  r_w_use, r_h_use;
    logic [bizm_pkg::DIM_W-1:0]  r_wq_est, r_hq_est;
    logic [bizm_pkg::DIM_W-1:0]  r_cell_w, r_cell_h;
    logic                        w_round_up, h_round_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= bizm_pkg::CFG_WIDTH_RST;
            r_cfg_height <= bizm_pkg::CFG_HEIGHT_RST;
            r_settle     <= bizm_pkg::SETTLE_CYCLES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bizm_pkg::CFG_IDX_WIDTH:  r_cfg_width  <= i_cfg_data;
                bizm_pkg::CFG_IDX_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
            r_settle <= bizm_pkg::SETTLE_CYCLES;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 1'b1;
        end
    end

    // Saturate the registers so that every cell is at least one pixel square.
    always_comb begin
        if (bizm_pkg::CMP_W'(r_cfg_width) < bizm_pkg::CMP_W'(bizm_pkg::GRID_COLS)) begin
            w_clamp = bizm_pkg::DIM_W'(bizm_pkg::GRID_COLS);
        end else if (bizm_pkg::CMP_W'(r_cfg_width) > bizm_pkg::CMP_W'(bizm_pkg::MAX_WIDTH)) begin
            w_clamp = bizm_pkg::DIM_W'(bizm_pkg::MAX_WIDTH);
        end else begin
            w_clamp = bizm_pkg::DIM_W'(r_cfg_width);
        end
        if (bizm_pkg::CMP_W'(r_cfg_height) < bizm_pkg::CMP_W'(bizm_pkg::GRID_ROWS)) begin
            h_clamp = bizm_pkg::DIM_W'(bizm_pkg::GRID_ROWS);
        end else if (bizm_pkg::CMP_W'(r_cfg_height) > bizm_pkg::CMP_W'(bizm_pkg::MAX_HEIGHT)) begin
            h_clamp = bizm_pkg::DIM_W'(bizm_pkg::MAX_HEIGHT);
        end else begin
            h_clamp = bizm_pkg::DIM_W'(r_cfg_height);
        end
    end

    // Cell size is the frame size over the grid count: a reciprocal multiply gives an
    // estimate that is exact or one low, and the next stage corrects it.
    assign w_prod = bizm_pkg::PROD_W'(w_clamp) * bizm_pkg::PROD_W'(bizm_pkg::RECIP_X);
    assign h_prod = bizm_pkg::PROD_W'(h_clamp) * bizm_pkg::PROD_W'(bizm_pkg::RECIP_Y);

    assign w_round_up = ((bizm_pkg::PROD_W'(r_wq_est) + bizm_pkg::PROD_W'(1))
                         * bizm_pkg::PROD_W'(bizm_pkg::GRID_COLS))
                        <= bizm_pkg::PROD_W'(r_w_use);
    assign h_round_up = ((bizm_pkg::PROD_W'(r_hq_est) + bizm_pkg::PROD_W'(1))
                         * bizm_pkg::PROD_W'(bizm_pkg::GRID_ROWS))
                        <= bizm_pkg::PROD_W'(r_h_use);

    always_ff @(posedge i_clk) begin
        r_w_use  <= w_clamp;
        r_h_use  <= h_clamp;
        r_wq_est <= bizm_pkg::DIM_W'(w_prod >> bizm_pkg::DIM_W);
        r_hq_est <= bizm_pkg::DIM_W'(h_prod >> bizm_pkg::DIM_W);
        r_cell_w <= w_round_up ? r_wq_est + 1'b1 : r_wq_est;
        r_cell_h <= h_round_up ? r_hq_est + 1'b1 : r_hq_est;
    end

    // ------------------------------------------------------------------
    // Control state machine.
    // ------------------------------------------------------------------
    bizm_pkg::t_state r_state, n_state;

    logic                       in_accept;
    logic                       out_accept;
    logic                       frame_end;
    logic                       div_done;
    logic [CW-1:0]              div_quot;
    logic [bizm_pkg::CELL_W-1:0] r_cell;
    logic                       cell_is_last;

    // Decoded controls.
    logic ctl_in_ready;
    logic ctl_div_start;
    logic ctl_emit_read;
    logic ctl_clear_zones;

    logic r_dark_zero;

    assign cell_is_last = (r_cell == bizm_pkg::CELL_W'(bizm_pkg::NUM_CELLS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            bizm_pkg::ST_RUN:   if (in_accept && frame_end) n_state = bizm_pkg::ST_START;
            bizm_pkg::ST_START: n_state = r_dark_zero ? bizm_pkg::ST_RD : bizm_pkg::ST_DIV;
            bizm_pkg::ST_DIV:   if (div_done) n_state = bizm_pkg::ST_RD;
            bizm_pkg::ST_RD:    n_state = bizm_pkg::ST_MUL;
            bizm_pkg::ST_MUL:   n_state = bizm_pkg::ST_CMP;
            bizm_pkg::ST_CMP:   n_state = bizm_pkg::ST_HOLD;
            bizm_pkg::ST_HOLD: begin
                if (out_accept) begin
                    n_state = cell_is_last ? bizm_pkg::ST_RUN : bizm_pkg::ST_RD;
                end
            end
            default: n_state = bizm_pkg::ST_RUN;
        endcase
    end

    always_comb begin
        ctl_in_ready    = 1'b0;
        ctl_div_start   = 1'b0;
        ctl_emit_read   = 1'b0;
        ctl_clear_zones = 1'b0;
        case (r_state)
            bizm_pkg::ST_RUN:   ctl_in_ready  = (r_settle == '0);
            bizm_pkg::ST_START: ctl_div_start = !r_dark_zero;
            bizm_pkg::ST_RD:    ctl_emit_read = 1'b1;
            bizm_pkg::ST_HOLD:  ctl_clear_zones = out_accept && cell_is_last;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bizm_pkg::ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = ctl_in_ready;
    assign in_accept  = i_in_valid && ctl_in_ready;
    assign out_accept = o_out_valid && i_out_ready;

    // ------------------------------------------------------------------
    // Raster position, tracked both as frame position and as the cell the
    // pixel falls in; a cell coordinate equal to the grid count means the
    // pixel lies in the leftover strip outside whole cells.
    // ------------------------------------------------------------------
    logic [bizm_pkg::POS_W-1:0] r_col, r_row, r_xin, r_yin;
    logic [bizm_pkg::GX_W-1:0]  r_cx;
    logic [bizm_pkg::GY_W-1:0]  r_cy;
    logic                       col_last, row_last, xin_last, yin_last;
    logic                       pix_white, pix_in_cell;
    logic [bizm_pkg::CELL_W-1:0] pix_cell;

    assign col_last  = (bizm_pkg::DIM_W'(r_col) + 1'b1) == r_w_use;
    assign row_last  = (bizm_pkg::DIM_W'(r_row) + 1'b1) == r_h_use;
    assign xin_last  = (bizm_pkg::DIM_W'(r_xin) + 1'b1) == r_cell_w;
    assign yin_last  = (bizm_pkg::DIM_W'(r_yin) + 1'b1) == r_cell_h;
    assign frame_end = col_last && row_last;

    assign pix_white = (i_red == bizm_pkg::WHITE_LEVEL) && (i_green == bizm_pkg::WHITE_LEVEL)
                       && (i_blue == bizm_pkg::WHITE_LEVEL);
    assign pix_in_cell = (r_cx < bizm_pkg::GX_W'(bizm_pkg::GRID_COLS))
                         && (r_cy < bizm_pkg::GY_W'(bizm_pkg::GRID_ROWS));
    assign pix_cell = bizm_pkg::CELL_W'(r_cx * bizm_pkg::GRID_ROWS + r_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_col <= '0;
            r_row <= '0;
            r_xin <= '0;
            r_yin <= '0;
            r_cx  <= '0;
            r_cy  <= '0;
        end else if (in_accept) begin
            if (col_last) begin
                r_col <= '0;
                r_xin <= '0;
                r_cx  <= '0;
                if (row_last) begin
                    r_row <= '0;
                    r_yin <= '0;
                    r_cy  <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                    if (yin_last) begin
                        r_yin <= '0;
                        if (r_cy != bizm_pkg::GY_W'(bizm_pkg::GRID_ROWS)) begin
                            r_cy <= r_cy + 1'b1;
                        end
                    end else begin
                        r_yin <= r_yin + 1'b1;
                    end
                end
            end else begin
                r_col <= r_col + 1'b1;
                if (xin_last) begin
                    r_xin <= '0;
                    if (r_cx != bizm_pkg::GX_W'(bizm_pkg::GRID_COLS)) begin
                        r_cx <= r_cx + 1'b1;
                    end
                end else begin
                    r_xin <= r_xin + 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Frame totals. They are handed to the divider at frame end, unless the
    // frame had no dark pixel, and cleared in the same cycle.
    // ------------------------------------------------------------------
    logic [CW-1:0] r_white_tot, r_dark_tot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || r_state == bizm_pkg::ST_START) begin
            r_white_tot <= '0;
            r_dark_tot  <= '0;
        end else if (in_accept) begin
            if (pix_white) begin
                r_white_tot <= r_white_tot + 1'b1;
            end else begin
                r_dark_tot <= r_dark_tot + 1'b1;
            end
        end
    end

    assign r_dark_zero = (r_dark_tot == '0);

    bizm_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctl_div_start),
        .i_dividend (r_white_tot),
        .i_divisor  (r_dark_tot),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // The coefficient of the last finished frame; zero when that frame had no dark pixel.
    logic [CW-1:0] r_coef;
    logic          r_no_dark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef    <= '0;
            r_no_dark <= 1'b0;
        end else if (r_state == bizm_pkg::ST_START) begin
            r_no_dark <= r_dark_zero;
            if (r_dark_zero) begin
                r_coef <= '0;
            end
        end else if (r_state == bizm_pkg::ST_DIV && div_done) begin
            r_coef <= div_quot;
        end
    end

    // ------------------------------------------------------------------
    // Cell count memory: one word per cell, dark count above white count.
    // Entries are empty until written; a cleared valid bit reads as zero.
    // A pixel reads its cell when accepted and writes the sum back in the
    // next cycle; a pixel that reads on the same edge as that write-back
    // takes the written word from the forwarding register instead.
    // ------------------------------------------------------------------
    logic [MW-1:0]                  r_zone_mem [bizm_pkg::NUM_CELLS];
    logic [bizm_pkg::NUM_CELLS-1:0] r_zone_vld;
    logic [MW-1:0]                  r_rd_data;
    logic [bizm_pkg::CELL_W-1:0]    rd_addr;

    logic                           r_s1_vld;
    logic                           r_s1_white;
    logic [bizm_pkg::CELL_W-1:0]    r_s1_addr;
    logic                           r_fwd_vld;
    logic [bizm_pkg::CELL_W-1:0]    r_fwd_addr;
    logic [MW-1:0]                  r_fwd_data;
    logic [MW-1:0]                  s1_base;
    logic [MW-1:0]                  s1_wdata;

    assign rd_addr = ctl_emit_read ? r_cell : pix_cell;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_zone_mem[rd_addr];
        if (r_s1_vld) begin
            r_zone_mem[r_s1_addr] <= s1_wdata;
        end
    end

    always_comb begin
        if (r_fwd_vld && r_fwd_addr == r_s1_addr) begin
            s1_base = r_fwd_data;
        end else if (r_zone_vld[r_s1_addr]) begin
            s1_base = r_rd_data;
        end else begin
            s1_base = '0;
        end
        if (r_s1_white) begin
            s1_wdata = {s1_base[MW-1:CW], s1_base[CW-1:0] + 1'b1};
        end else begin
            s1_wdata = {s1_base[MW-1:CW] + 1'b1, s1_base[CW-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_s1_vld   <= 1'b0;
            r_fwd_vld  <= 1'b0;
            r_zone_vld <= '0;
        end else begin
            r_s1_vld  <= in_accept && pix_in_cell;
            r_fwd_vld <= r_s1_vld;
            if (ctl_clear_zones) begin
                r_zone_vld <= '0;
            end else if (r_s1_vld) begin
                r_zone_vld[r_s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_white <= pix_white;
        r_s1_addr  <= pix_cell;
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= s1_wdata;
    end

    // ------------------------------------------------------------------
    // Emission: per cell, read the memory, multiply the dark count by the
    // coefficient, compare with the white count, then present the result
    // until the transaction completes.
    // ------------------------------------------------------------------
    logic [MW-1:0] em_word;
    logic [MW-1:0] r_prod;
    logic [CW-1:0] r_em_white;

    assign em_word = r_zone_vld[r_cell] ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else if (r_state == bizm_pkg::ST_START) begin
            r_cell <= '0;
        end else if (r_state == bizm_pkg::ST_HOLD && out_accept && !cell_is_last) begin
            r_cell <= r_cell + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bizm_pkg::ST_MUL) begin
            r_prod     <= MW'(em_word[MW-1:CW]) * MW'(r_coef);
            r_em_white <= em_word[CW-1:0];
        end
    end

    logic                               r_o_valid;
    logic [bizm_pkg::IDX_W-1:0]         r_o_cell_index;
    logic signed [bizm_pkg::VOTE_W-1:0] r_o_vote;
    logic                               r_o_no_dark;
    logic                               r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == bizm_pkg::ST_CMP) begin
            r_o_valid <= 1'b1;
        end else if (out_accept) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bizm_pkg::ST_CMP) begin
            r_o_cell_index <= bizm_pkg::IDX_W'(r_cell);
            r_o_vote       <= (r_prod >= MW'(r_em_white)) ? bizm_pkg::VOTE_UP
                                                          : bizm_pkg::VOTE_DOWN;
            r_o_no_dark    <= r_no_dark;
            r_o_last       <= cell_is_last;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_cell_index   = r_o_cell_index;
    assign o_cell_vote    = r_o_vote;
    assign o_no_dark_flag = r_o_no_dark;
    assign o_last_cell    = r_o_last;

`ifndef SYNTHESIS
    // Pixels and results never flow at the same time.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a cell result is pending");

    // The last pixel of a frame always starts the frame-end sequence.
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && frame_end) |=> (r_state == bizm_pkg::ST_START))
        else $error("frame end did not start the coefficient step");

    // A write-back is only in flight right after a pixel was taken.
    a_wb_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (r_state == bizm_pkg::ST_RUN || r_state == bizm_pkg::ST_START))
        else $error("cell write-back outside pixel flow");

    // A result is shown only while the block waits for it to be taken.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == bizm_pkg::ST_HOLD))
        else $error("result valid outside the hold state");
`endif

endmodule

@@ sv/bizm_divider.sv @@
// Restoring integer divider, one quotient bit per cycle.
module bizm_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bizm_pkg::COUNT_W-1:0] i_dividend,
    input  logic [bizm_pkg::COUNT_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [bizm_pkg::COUNT_W-1:0] o_quotient
);

    logic                         r_busy;
    logic                         r_done;
    logic [bizm_pkg::STEP_W-1:0]  r_step;
    logic [bizm_pkg::COUNT_W-1:0] r_rem;
    logic [bizm_pkg::COUNT_W-1:0] r_quot;
    logic [bizm_pkg::COUNT_W-1:0] r_div;
    logic [bizm_pkg::COUNT_W:0]   shifted;
    logic                         fits;

    assign shifted = {r_rem, r_quot[bizm_pkg::COUNT_W-1]};
    assign fits    = (shifted >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == bizm_pkg::STEP_W'(bizm_pkg::COUNT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= bizm_pkg::COUNT_W'(shifted - {1'b0, r_div});
            end else begin
                r_rem <= bizm_pkg::COUNT_W'(shifted);
            end
            r_quot <= {r_quot[bizm_pkg::COUNT_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule
